// ===== design/binary_insertion_sorter_defines.svh =====
// Assertion macros for the binary insertion sorter.
// Used by binary_insertion_sorter.sv; expects clock and reset in scope.
`ifndef BINARY_INSERTION_SORTER_DEFINES_SVH
`define BINARY_INSERTION_SORTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BIS_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("binary_insertion_sorter: assertion failed");

// Next-cycle implication, checked outside reset.
`define BIS_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("binary_insertion_sorter: assertion failed");

`endif

// ===== design/bis_pkg.sv =====
// Shared types for the binary insertion sorter.
// No dependencies; used by binary_insertion_sorter.sv.
`default_nettype none

package bis_pkg;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      final_res;
      logic                      overflow;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/binary_insertion_sorter.sv =====
// Steps: a non-last item is accepted, then each binary-search step reads the store and narrows
// the range (up to 6 over 63 entries), the search ends, entries move up one place and the key is
// written. A last item then reads out its results in turn, each also held by output stalls.
// Throughput: one item at a time; the next is taken after the write-back and any result read-out.
// Reset (synchronous, active high) empties the store count, clears the overflow flag and output
// valid and sets ascending order; store contents need no clearing pass.
`default_nettype none

`include "binary_insertion_sorter_defines.svh"

module binary_insertion_sorter #(
   parameter int CAPACITY = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bis_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bis_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SEARCH    = 3'd1;
   localparam logic [2:0] ST_SWAIT     = 3'd2;
   localparam logic [2:0] ST_SHIFT     = 3'd3;
   localparam logic [2:0] ST_EMIT_RD   = 3'd4;
   localparam logic [2:0] ST_EMIT_WAIT = 3'd5;

   // sorted store, one write and one read port, registered read
   logic signed [bis_pkg::VALUE_W-1:0] mem [CAPACITY];
   logic signed [bis_pkg::VALUE_W-1:0] rd_ff;
   logic                               mem_we;
   logic [AW-1:0]                      mem_wa;
   logic signed [bis_pkg::VALUE_W-1:0] mem_wd;
   logic [AW-1:0]                      mem_ra;

   logic [2:0]                         state_ff, state_in;
   logic signed [bis_pkg::VALUE_W-1:0] key_ff, key_in;
   logic                               last_ff, last_in;
   logic [CW-1:0]                      lo_ff, lo_in;
   logic [CW-1:0]                      hi_ff, hi_in;
   logic [CW-1:0]                      k_ff, k_in;
   logic                               pw_ff, pw_in;
   logic [AW-1:0]                      wa_ff, wa_in;
   logic [AW-1:0]                      e_ff, e_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic                               drop_ff, drop_in;
   logic                               asc_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   bis_pkg::rsp_type                   rsp_ff, rsp_in;

   logic [CW:0]   mid_sum;
   logic [AW-1:0] mid;
   logic [CW-1:0] km1;
   logic          goes_before;
   logic          emit_final;

   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[AW:1];
   assign km1         = k_ff - 1'b1;
   assign goes_before = asc_ff ? (key_ff < rd_ff) : (key_ff > rd_ff);
   assign emit_final  = (CW'(e_ff) + 1'b1) == count_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      k_in         = k_ff;
      pw_in        = pw_ff;
      wa_in        = wa_ff;
      e_in         = e_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_wa       = wa_ff;
      mem_wd       = rd_ff;
      mem_ra       = mid;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in  = req_data.value;
               last_in = req_data.last;
               lo_in   = '0;
               hi_in   = count_ff;
               if (count_ff == CAP_COUNT) begin
                  // store full: drop the value
                  drop_in  = 1'b1;
                  e_in     = '0;
                  state_in = req_data.last ? ST_EMIT_RD : ST_IDLE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mem_ra   = mid;
               state_in = ST_SWAIT;
            end else begin
               k_in     = count_ff;
               pw_in    = 1'b0;
               state_in = ST_SHIFT;
            end
         end
         ST_SWAIT: begin
            if (goes_before) begin
               hi_in = CW'(mid);
            end else begin
               lo_in = CW'(mid) + 1'b1;
            end
            state_in = ST_SEARCH;
         end
         ST_SHIFT: begin
            // write back the entry read last cycle one place up
            if (pw_ff) begin
               mem_we = 1'b1;
               mem_wa = wa_ff;
               mem_wd = rd_ff;
            end
            if (k_ff > lo_ff) begin
               mem_ra = km1[AW-1:0];
               wa_in  = k_ff[AW-1:0];
               pw_in  = 1'b1;
               k_in   = km1;
            end else if (pw_ff) begin
               pw_in = 1'b0;
            end else begin
               mem_we   = 1'b1;
               mem_wa   = lo_ff[AW-1:0];
               mem_wd   = key_ff;
               count_in = count_ff + 1'b1;
               e_in     = '0;
               state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            // hold until the output register is free
            if (!rsp_valid_ff) begin
               mem_ra   = e_ff;
               state_in = ST_EMIT_WAIT;
            end
         end
         ST_EMIT_WAIT: begin
            rsp_in.sorted_value = rd_ff;
            rsp_in.final_res    = emit_final;
            rsp_in.overflow     = drop_ff;
            rsp_valid_in        = 1'b1;
            if (emit_final) begin
               count_in = '0;
               drop_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         pw_ff        <= 1'b0;
         asc_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         pw_ff        <= pw_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            asc_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      last_ff <= last_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      k_ff    <= k_in;
      wa_ff   <= wa_in;
      e_ff    <= e_in;
      rsp_ff  <= rsp_in;
   end

   `BIS_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CAP_COUNT)
   `BIS_ASSERT_IMP(a_search_order, state_ff == ST_SEARCH, lo_ff <= hi_ff)
   `BIS_ASSERT_IMP(a_shift_above, (state_ff == ST_SHIFT) && pw_ff, CW'(wa_ff) > lo_ff)
   `BIS_ASSERT_IMP(a_final_clears, $rose(rsp_valid_ff) && rsp_ff.final_res, count_ff == '0)

endmodule

`default_nettype wire

// ===== tb/tb_binary_insertion_sorter.sv =====
`timescale 1ns / 100ps
// Testbench for binary_insertion_sorter: directed and random sets of signed values, with each
// sorted result checked field by field against a sorted-store predictor held in this file.
// Depends on bis_pkg and the binary_insertion_sorter module.
module tb_binary_insertion_sorter;

   localparam int CAPACITY      = 64;
   localparam int VALUE_W       = bis_pkg::VALUE_W;
   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES   = 600;
   localparam int QUIET_LIMIT   = 5000;
   localparam int MAX_PRINTED   = 20;

   localparam logic signed [VALUE_W-1:0] MAX_VALUE = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} stall_mode_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   bis_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   bis_pkg::rsp_type rsp_data;
   logic             csr_wr_en;
   logic             csr_wr_data;
   logic             rsp_hold = 1'b0;

   // predictor copy of the block's state and register
   logic signed [VALUE_W-1:0] held_values[CAPACITY];
   int                        held_count = 0;
   bit                        values_dropped = 1'b0;
   bit                        ascending_order = 1'b1;
   bis_pkg::rsp_type          expected_sorted[$];

   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int runs_closed = 0;
   int overflow_runs = 0;
   int burst_left = 0;
   int quiet_cycles = 0;

   binary_insertion_sorter #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic bit goes_first(input logic signed [VALUE_W-1:0] key,
                                     input logic signed [VALUE_W-1:0] held);
      return ascending_order ? (key < held) : (key > held);
   endfunction

   // Insert one accepted item, or mark it dropped when the store is full; on a last item queue the whole sorted list.
   function automatic void predict_insert(input bis_pkg::req_type item);
      int               lo;
      int               hi;
      int               mid;
      bis_pkg::rsp_type result;
      lo = 0;
      hi = held_count;
      if (held_count >= CAPACITY) begin
         values_dropped = 1'b1;
      end else begin
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (goes_first(item.value, held_values[mid])) hi = mid;
            else lo = mid + 1;
         end
         for (int k = held_count; k > lo; k--) held_values[k] = held_values[k-1];
         held_values[lo] = item.value;
         held_count++;
      end
      if (item.last) begin
         for (int k = 0; k < held_count; k++) begin
            result.sorted_value = held_values[k];
            result.final_res    = (k + 1 == held_count);
            result.overflow     = values_dropped;
            expected_sorted.push_back(result);
         end
         runs_closed++;
         if (values_dropped) overflow_runs++;
         held_count     = 0;
         values_dropped = 1'b0;
      end
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6, 7:       return $signed($urandom_range(0, 8)) - 4;
         8:             return $urandom_range(0, 1) ? MAX_VALUE : MIN_VALUE;
         default:       return $urandom_range(0, 1) ? MAX_VALUE - $urandom_range(0, 3)
                                                    : MIN_VALUE + $urandom_range(0, 3);
      endcase
   endfunction

   // Offer one item in bursts with random gaps; return once it is accepted.
   task automatic send_item(input logic signed [VALUE_W-1:0] val, input bit is_last);
      int gap;
      bis_pkg::req_type item;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 8);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      item.value = val;
      item.last  = is_last;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      items_sent++;
      predict_insert(item);
   endtask

   task automatic send_set(input logic signed [VALUE_W-1:0] vals[$], input bit close_run);
      foreach (vals[i]) send_item(vals[i], close_run && (i == vals.size() - 1));
   endtask

   task automatic send_random_run(input int len);
      for (int i = 0; i < len; i++) send_item(random_value(), i == len - 1);
   endtask

   // Drop valid, wait for every expected result, then let an insertion finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input bit asc);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= asc;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ascending_order = asc;
   endtask

   task automatic hold_receiver();
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   task automatic test_ascending_extremes();
      logic signed [VALUE_W-1:0] vals[$];
      vals = '{0, MAX_VALUE, MIN_VALUE, -1, 1, 1, -2, 0};
      write_order(1'b1);
      send_set(vals, 1'b1);
      wait_idle();
   endtask

   task automatic test_single_item_run();
      send_item(MIN_VALUE, 1'b1);
      wait_idle();
   endtask

   task automatic test_descending();
      logic signed [VALUE_W-1:0] vals[$];
      vals = '{5, MAX_VALUE, -7, MIN_VALUE, 5, 0};
      write_order(1'b0);
      send_set(vals, 1'b1);
      wait_idle();
   endtask

   // Entries held before the switch keep their place; later searches use the new order.
   task automatic test_order_change_mid_run();
      logic signed [VALUE_W-1:0] first_part[$];
      logic signed [VALUE_W-1:0] second_part[$];
      first_part  = '{10, -3, 4};
      second_part = '{7, -20};
      write_order(1'b1);
      send_set(first_part, 1'b0);
      wait_idle();
      write_order(1'b0);
      send_set(second_part, 1'b1);
      wait_idle();
   endtask

   // Overfill the store, then hold the receiver so the next run stalls at the input.
   task automatic test_overflow_under_pressure();
      write_order(1'b1);
      send_random_run(CAPACITY + 2);
      fork
         hold_receiver();
      join_none
      send_random_run(4);
      wait_idle();
   endtask

   task automatic test_random_runs(input int item_budget);
      int sent;
      int len;
      sent = 0;
      while (sent < item_budget) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            write_order($urandom_range(0, 1));
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         if (len > item_budget - sent) len = item_budget - sent;
         send_random_run(len);
         sent += len;
      end
      wait_idle();
   endtask

   initial begin : receiver
      stall_mode_type mode;
      int             mode_cycles;
      mode        = READY_ALWAYS;
      mode_cycles = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_cycles == 0) begin
            mode        = stall_mode_type'($urandom_range(0, 3));
            mode_cycles = $urandom_range(16, 96);
         end
         mode_cycles--;
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               READY_ALWAYS:   rsp_ready <= 1'b1;
               READY_COIN:     rsp_ready <= $urandom_range(0, 1);
               READY_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
               READY_PERIODIC: rsp_ready <= (mode_cycles % 3 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      bis_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_sorted.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none expected",
                                      rsp_data.sorted_value));
         end else begin
            want = expected_sorted.pop_front();
            if (rsp_data.sorted_value !== want.sorted_value)
               report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                         rsp_data.sorted_value, want.sorted_value));
            if (rsp_data.final_res !== want.final_res)
               report_mismatch($sformatf("final_res %b, expected %b",
                                         rsp_data.final_res, want.final_res));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_data.overflow, want.overflow));
         end
      end
   end

   // End the run if no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("** binary_insertion_sorter: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ascending_extremes();
      test_single_item_run();
      test_descending();
      test_order_change_mid_run();
      test_overflow_under_pressure();
      test_random_runs(30);

      wait_idle();
      if (expected_sorted.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_sorted.size()));
      $display("covered %0d items in %0d sorted runs (%0d with dropped values), %0d results",
               items_sent, runs_closed, overflow_runs, results_checked);
      $display("both orders, a mid-run order switch, a full store and a long output stall");
      if (error_count == 0) begin
         $display("** binary_insertion_sorter: PASSED **");
      end else begin
         $display("** binary_insertion_sorter: FAILED **");
      end
      $finish;
   end

endmodule
